// ----- design/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, register map, channel payload types and capacity clamp.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 5;
    localparam int DATA_W  = 32;

    localparam int REG_IDX_W = 1;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    localparam logic [OCC_W-1:0] CAP_RESET = OCC_W'((ENTRIES < 16) ? ENTRIES : 16);

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] write_value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } t_rsp;

    typedef struct packed {
        logic step;
        logic flush;
    } t_ctrl;

    function automatic logic [OCC_W-1:0] cap_clamp(input logic [CFG_W-1:0] v);
        logic [OCC_W-1:0] c;
        if (v == '0) begin
            c = OCC_W'(1);
        end else if (32'(v) > ENTRIES) begin
            c = OCC_W'(ENTRIES);
        end else begin
            c = OCC_W'(v);
        end
        return c;
    endfunction

endpackage

// ----- design/lkvc_ifs.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache channels
// Request and response valid/ready interfaces.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic signed [lkvc_pkg::KEY_W-1:0] key;
    logic signed [lkvc_pkg::VAL_W-1:0] write_value;

    modport source (output valid, output mode, output key, output write_value, input ready);
    modport sink   (input valid, input mode, input key, input write_value, output ready);
endinterface

interface lkvc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic signed [lkvc_pkg::VAL_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ----- design/lkvc_core.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Entry storage, parallel key match, recency ages and replacement.
// ----------------------------------------------------------------------------
module lkvc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lkvc_pkg::t_ctrl               i_ctrl,
    input  lkvc_pkg::t_req                i_req,
    input  logic [lkvc_pkg::OCC_W-1:0]    i_cap,
    output lkvc_pkg::t_rsp                o_rsp
);

    logic [lkvc_pkg::KEY_W-1:0] r_key_store   [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0] r_value_store [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::ENTRIES-1:0] r_valid;
    logic [lkvc_pkg::ENTRIES-1:0] n_valid;
    logic [lkvc_pkg::IDX_W-1:0]   r_age [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::IDX_W-1:0]   n_age [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::OCC_W-1:0]   r_occ;
    logic [lkvc_pkg::OCC_W-1:0]   n_occ;

    logic [lkvc_pkg::ENTRIES-1:0] w_match;
    logic [lkvc_pkg::ENTRIES-1:0] w_young;
    logic [lkvc_pkg::IDX_W-1:0]   w_found;
    logic [lkvc_pkg::IDX_W-1:0]   w_free;
    logic [lkvc_pkg::IDX_W-1:0]   w_victim;
    logic [lkvc_pkg::IDX_W-1:0]   w_slot;
    logic [lkvc_pkg::IDX_W-1:0]   w_oldest;
    logic [lkvc_pkg::IDX_W-1:0]   w_old_age;
    logic                         w_hit;
    logic                         w_full;
    logic                         w_is_set;

    always_comb begin
        w_oldest = lkvc_pkg::IDX_W'(r_occ - lkvc_pkg::OCC_W'(1));
        w_found  = '0;
        w_free   = '0;
        w_victim = '0;
        for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_key_store[i] == i_req.key);
            w_young[i] = r_valid[i] && (r_age[i] == '0);
            if (w_match[i]) begin
                w_found = lkvc_pkg::IDX_W'(i);
            end
            if (!r_valid[i]) begin
                w_free = lkvc_pkg::IDX_W'(i);
            end
            if (r_valid[i] && (r_age[i] == w_oldest)) begin
                w_victim = lkvc_pkg::IDX_W'(i);
            end
        end
        w_hit     = |w_match;
        w_old_age = r_age[w_found];
        w_full    = (r_occ >= i_cap);
        w_slot    = w_full ? w_victim : w_free;
        w_is_set  = (i_req.mode == lkvc_pkg::MODE_SET);
    end

    always_comb begin
        n_valid = r_valid;
        n_age   = r_age;
        n_occ   = r_occ;
        if (i_ctrl.flush) begin
            n_valid = '0;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                n_age[i] = '0;
            end
            n_occ = '0;
        end else if (i_ctrl.step) begin
            if (w_hit) begin
                for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                    if (r_valid[i] && (r_age[i] < w_old_age)) begin
                        n_age[i] = r_age[i] + lkvc_pkg::IDX_W'(1);
                    end
                end
                n_age[w_found] = '0;
            end else if (w_is_set) begin
                for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                    if (r_valid[i] && (lkvc_pkg::IDX_W'(i) != w_slot)) begin
                        n_age[i] = r_age[i] + lkvc_pkg::IDX_W'(1);
                    end
                end
                n_age[w_slot]   = '0;
                n_valid[w_slot] = 1'b1;
                if (!w_full) begin
                    n_occ = r_occ + lkvc_pkg::OCC_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_rsp.hit        = w_hit;
        o_rsp.read_value = (w_hit && !w_is_set) ? r_value_store[w_found] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                r_age[i] <= '0;
            end
            r_occ <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step && !i_ctrl.flush && w_is_set) begin
            if (w_hit) begin
                r_value_store[w_found] <= i_req.write_value;
            end else begin
                r_key_store[w_slot]   <= i_req.key;
                r_value_store[w_slot] <= i_req.write_value;
            end
        end
    end

    a_occ_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= i_cap) else $error("occupancy above capacity");

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_occ)) else $error("occupancy out of step with valid bits");

    a_single_youngest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != '0) |-> $onehot(w_young)) else $error("no unique most recent entry");

    a_set_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.step && !i_ctrl.flush && w_is_set) |=> (r_occ != '0))
        else $error("set left the cache empty");

endmodule

// ----- design/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative get/set store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_req     in   valid/ready      mode, key, write_value
//  o_rsp     out  valid/ready      hit, read_value
//  apb       in   psel/penable     capacity at byte address 0
//
//  One item per cycle while o_rsp does not stall; an accepted item passes the
//  request register, then the result register behind the combinational lookup.
//  Synchronous reset empties the cache and sets capacity to 16.
//  i_req.ready drops only while both registers hold items and o_rsp stalls.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lkvc_req_if.sink                        i_req,
    lkvc_rsp_if.source                      o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lkvc_pkg::ADDR_W-1:0]     paddr,
    input  logic [lkvc_pkg::DATA_W-1:0]     pwdata,
    output logic [lkvc_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    logic                           r_in_valid;
    lkvc_pkg::t_req                 r_in;
    logic                           r_out_valid;
    lkvc_pkg::t_rsp                 r_out;
    logic [lkvc_pkg::OCC_W-1:0]     r_cap;

    logic                           w_advance;
    logic                           w_accept;
    logic                           w_cfg_sel;
    logic                           w_cfg_we;
    lkvc_pkg::t_ctrl                w_ctrl;
    lkvc_pkg::t_rsp                 w_rsp;

    assign w_advance = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_advance;
    assign w_accept  = i_req.valid && i_req.ready;

    assign w_cfg_sel = (paddr[lkvc_pkg::ADDR_W-1:2] == lkvc_pkg::REG_CAPACITY);
    assign w_cfg_we  = psel && penable && pwrite && w_cfg_sel;
    assign pready    = 1'b1;
    assign prdata    = w_cfg_sel ? lkvc_pkg::DATA_W'(r_cap) : '0;

    assign w_ctrl.step  = w_advance;
    assign w_ctrl.flush = w_cfg_we;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out.hit;
    assign o_rsp.read_value = r_out.read_value;

    lkvc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_req   (r_in),
        .i_cap   (r_cap),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= lkvc_pkg::CAP_RESET;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_we) begin
                r_cap <= lkvc_pkg::cap_clamp(pwdata[lkvc_pkg::CFG_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.mode        <= i_req.mode;
            r_in.key         <= i_req.key;
            r_in.write_value <= i_req.write_value;
        end
        if (w_advance) begin
            r_out <= w_rsp;
        end
    end

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !w_advance) else $error("result overwritten");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("item taken while stalled");

    a_cap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cap != '0) && (32'(r_cap) <= lkvc_pkg::ENTRIES)) else $error("capacity out of range");

endmodule
